/* src/assert_macros.svh */
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and reset.
`define CLZ_ASSERT_CLK(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define CLZ_ASSERT(name, prop, msg) \
   `CLZ_ASSERT_CLK(name, clock, reset, prop, msg)

`endif

/* src/clzrank_pkg.sv */
`default_nettype none
package clzrank_pkg;

   localparam int TABLE_ENTRIES = 10;
   localparam int STEP_LIMIT    = 4095;
   localparam int WORK_WIDTH    = 64;

   localparam int NUMBER_W = 32;
   localparam int INDEX_W  = 4;
   localparam int RANK_W   = 4;
   localparam int STEPS_W  = 12;
   localparam int IDX_W    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   localparam int STEPS_FIELD_MAX = (2 ** STEPS_W) - 1;
   localparam int EFF_LIMIT_INT   = (STEP_LIMIT > STEPS_FIELD_MAX) ? STEPS_FIELD_MAX
                                                                    : STEP_LIMIT;
   localparam logic [STEPS_W-1:0] EFF_LIMIT = STEPS_W'(EFF_LIMIT_INT);

   // Largest value whose 3n+1 still fits the working width.
   localparam logic [WORK_WIDTH-1:0] WORK_MAX = '1;
   localparam logic [WORK_WIDTH-1:0] ODD_MAX  = (WORK_MAX - 1'b1) / 2'd3;

   localparam logic OP_EVAL = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef struct packed {
      logic load;
      logic advance;
   } walk_ctl_type;

   typedef struct packed {
      logic finished;
      logic wide_overflow;
      logic limit_hit;
   } walk_stat_type;

   typedef struct packed {
      logic scan;
      logic insert;
   } tbl_ctl_type;

   typedef struct packed {
      logic             admit;
      logic [IDX_W-1:0] pos;
   } scan_res_type;

endpackage
`default_nettype wire

/* src/clzrank_ifs.sv */
`default_nettype none
interface clzrank_req_if;
   import clzrank_pkg::*;
   logic                valid;
   logic                ready;
   logic                op;
   logic [NUMBER_W-1:0] value;
   logic [INDEX_W-1:0]  index;

   modport source (output valid, output op, output value, output index, input ready);
   modport sink   (input valid, input op, input value, input index, output ready);
endinterface

interface clzrank_rsp_if;
   import clzrank_pkg::*;
   logic                valid;
   logic                ready;
   logic [STEPS_W-1:0]  steps;
   logic                admitted;
   logic [RANK_W-1:0]   rank;
   logic                wide_overflow;
   logic                limit_hit;
   logic [NUMBER_W-1:0] entry_number;
   logic [STEPS_W-1:0]  entry_steps;

   modport source (output valid, output steps, output admitted, output rank,
                   output wide_overflow, output limit_hit, output entry_number,
                   output entry_steps, input ready);
   modport sink   (input valid, input steps, input admitted, input rank,
                   input wide_overflow, input limit_hit, input entry_number,
                   input entry_steps, output ready);
endinterface
`default_nettype wire

/* src/clzrank_walk.sv */
`default_nettype none
module clzrank_walk
   import clzrank_pkg::*;
(
   input  wire logic                clock,
   input  wire walk_ctl_type        ctl,
   input  wire logic [NUMBER_W-1:0] load_value,
   output walk_stat_type            stat,
   output logic [STEPS_W-1:0]       count
);

   logic [WORK_WIDTH-1:0] n_ff, n_in;
   logic [STEPS_W-1:0]    count_ff, count_in;
   logic [WORK_WIDTH-1:0] triple;
   logic                  at_one, at_limit, odd_over;

   // The one shared step unit: either 3n+1 or a halving each cycle while advancing and not finished.
   assign triple   = {n_ff[WORK_WIDTH-2:0], 1'b0} + n_ff + {{(WORK_WIDTH-1){1'b0}}, 1'b1};
   assign at_one   = (n_ff[WORK_WIDTH-1:1] == '0);
   assign at_limit = (count_ff >= EFF_LIMIT);
   assign odd_over = n_ff[0] && (n_ff > ODD_MAX);

   assign stat.finished      = at_one || at_limit || odd_over;
   assign stat.limit_hit     = !at_one && at_limit;
   assign stat.wide_overflow = !at_one && !at_limit && odd_over;
   assign count              = count_ff;

   always_comb begin
      n_in     = n_ff;
      count_in = count_ff;
      if (ctl.load) begin
         n_in     = WORK_WIDTH'(load_value);
         count_in = '0;
      end else if (ctl.advance && !stat.finished) begin
         n_in     = n_ff[0] ? triple : {1'b0, n_ff[WORK_WIDTH-1:1]};
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      count_ff <= count_in;
   end

endmodule
`default_nettype wire

/* src/clzrank_table.sv */
`default_nettype none
module clzrank_table
   import clzrank_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire tbl_ctl_type         ctl,
   input  wire logic [STEPS_W-1:0]  count,
   input  wire logic [NUMBER_W-1:0] new_number,
   input  wire logic [INDEX_W-1:0]  rd_index,
   output scan_res_type             scan_res,
   output logic [NUMBER_W-1:0]      rd_number,
   output logic [STEPS_W-1:0]       rd_steps
);

   logic [NUMBER_W-1:0] num_ff [TABLE_ENTRIES];
   logic [NUMBER_W-1:0] num_in [TABLE_ENTRIES];
   logic [STEPS_W-1:0]  len_ff [TABLE_ENTRIES];
   logic [STEPS_W-1:0]  len_in [TABLE_ENTRIES];
   scan_res_type        scan_ff, scan_in;
   logic                dup, found;
   logic [IDX_W-1:0]    pos;

   // Lengths are kept strictly descending, so the entries longer than the
   // new count form a prefix and the first shorter one is the insert point.
   always_comb begin
      dup   = 1'b0;
      found = 1'b0;
      pos   = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (len_ff[i] == count) begin
            dup = 1'b1;
         end
         if (!found && !(len_ff[i] > count)) begin
            found = 1'b1;
            pos   = IDX_W'(i);
         end
      end
      scan_in = scan_ff;
      if (ctl.scan) begin
         scan_in.admit = !dup && (count > len_ff[TABLE_ENTRIES-1]);
         scan_in.pos   = pos;
      end
   end

   always_comb begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         num_in[i] = num_ff[i];
         len_in[i] = len_ff[i];
         if (ctl.insert) begin
            if (IDX_W'(i) == scan_ff.pos) begin
               num_in[i] = new_number;
               len_in[i] = count;
            end else if ((i > 0) && (IDX_W'(i) > scan_ff.pos)) begin
               num_in[i] = num_ff[(i > 0) ? i - 1 : 0];
               len_in[i] = len_ff[(i > 0) ? i - 1 : 0];
            end
         end
      end
   end

   // Ranks past the end of the table read as an empty entry.
   always_comb begin
      rd_number = '0;
      rd_steps  = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (32'(rd_index) == i) begin
            rd_number = num_ff[i];
            rd_steps  = len_ff[i];
         end
      end
   end

   assign scan_res = scan_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            num_ff[i] <= '0;
            len_ff[i] <= '0;
         end
         scan_ff <= '0;
      end else begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            num_ff[i] <= num_in[i];
            len_ff[i] <= len_in[i];
         end
         scan_ff <= scan_in;
      end
   end

endmodule
`default_nettype wire

/* src/collatz_length_top_ranker.sv */
// Channel    Direction  Beat contents
// req_chan   in         op, value, index
// rsp_chan   out        steps, admitted, rank, wide_overflow, limit_hit,
//                       entry_number, entry_steps
//
// An evaluate beat is loaded, walks the shared step unit (one Collatz step per
// cycle) until it finishes, scans the table, then inserts and posts the result.
// A read beat posts the addressed entry. Both post once the output is free.
// Synchronous reset clears the whole ranking table at once; no clearing pass.
// A stalled result waits in the output register; the next request beat is
// taken meanwhile, and the sequencer holds before posting its own result.
`default_nettype none
module collatz_length_top_ranker
   import clzrank_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   clzrank_req_if.sink   req_chan,
   clzrank_rsp_if.source rsp_chan
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_WALK  = 5'b00010,
      ST_READ  = 5'b00100,
      ST_SCAN  = 5'b01000,
      ST_WRITE = 5'b10000
   } state_type;

   state_type           state_ff, state_in;
   logic [NUMBER_W-1:0] value_ff, value_in;
   logic [INDEX_W-1:0]  index_ff, index_in;
   logic                ovf_ff, ovf_in;
   logic                hit_ff, hit_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STEPS_W-1:0]  steps_ff, steps_in;
   logic                admitted_ff, admitted_in;
   logic [RANK_W-1:0]   rank_ff, rank_in;
   logic                wovf_ff, wovf_in;
   logic                lhit_ff, lhit_in;
   logic [NUMBER_W-1:0] enum_ff, enum_in;
   logic [STEPS_W-1:0]  esteps_ff, esteps_in;

   walk_ctl_type        walk_ctl;
   walk_stat_type       walk_stat;
   logic [STEPS_W-1:0]  count;
   tbl_ctl_type         tbl_ctl;
   scan_res_type        scan_res;
   logic [NUMBER_W-1:0] rd_number;
   logic [STEPS_W-1:0]  rd_steps;
   logic                req_beat, out_free, admit;

   assign req_beat = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign admit    = scan_res.admit && !ovf_ff && !hit_ff;

   clzrank_walk u_walk (
      .clock      (clock),
      .ctl        (walk_ctl),
      .load_value (req_chan.value),
      .stat       (walk_stat),
      .count      (count)
   );

   clzrank_table u_table (
      .clock      (clock),
      .reset      (reset),
      .ctl        (tbl_ctl),
      .count      (count),
      .new_number (value_ff),
      .rd_index   (index_ff),
      .scan_res   (scan_res),
      .rd_number  (rd_number),
      .rd_steps   (rd_steps)
   );

   always_comb begin
      state_in       = state_ff;
      value_in       = value_ff;
      index_in       = index_ff;
      ovf_in         = ovf_ff;
      hit_in         = hit_ff;
      walk_ctl       = '0;
      tbl_ctl        = '0;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      steps_in       = steps_ff;
      admitted_in    = admitted_ff;
      rank_in        = rank_ff;
      wovf_in        = wovf_ff;
      lhit_in        = lhit_ff;
      enum_in        = enum_ff;
      esteps_in      = esteps_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               value_in      = req_chan.value;
               index_in      = req_chan.index;
               ovf_in        = 1'b0;
               hit_in        = 1'b0;
               walk_ctl.load = (req_chan.op == OP_EVAL);
               state_in      = (req_chan.op == OP_READ) ? ST_READ : ST_WALK;
            end
         end
         ST_WALK: begin
            walk_ctl.advance = 1'b1;
            if (walk_stat.finished) begin
               ovf_in   = walk_stat.wide_overflow;
               hit_in   = walk_stat.limit_hit;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            tbl_ctl.scan = 1'b1;
            state_in     = ST_WRITE;
         end
         ST_WRITE: begin
            if (out_free) begin
               tbl_ctl.insert = admit;
               rsp_valid_in   = 1'b1;
               steps_in       = count;
               admitted_in    = admit;
               rank_in        = admit ? RANK_W'(scan_res.pos) : '0;
               wovf_in        = ovf_ff;
               lhit_in        = hit_ff;
               enum_in        = '0;
               esteps_in      = '0;
               state_in       = ST_IDLE;
            end
         end
         ST_READ: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               steps_in     = '0;
               admitted_in  = 1'b0;
               rank_in      = '0;
               wovf_in      = 1'b0;
               lhit_in      = 1'b0;
               enum_in      = rd_number;
               esteps_in    = rd_steps;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      value_ff    <= value_in;
      index_ff    <= index_in;
      ovf_ff      <= ovf_in;
      hit_ff      <= hit_in;
      steps_ff    <= steps_in;
      admitted_ff <= admitted_in;
      rank_ff     <= rank_in;
      wovf_ff     <= wovf_in;
      lhit_ff     <= lhit_in;
      enum_ff     <= enum_in;
      esteps_ff   <= esteps_in;
   end

   assign req_chan.ready         = (state_ff == ST_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.steps         = steps_ff;
   assign rsp_chan.admitted      = admitted_ff;
   assign rsp_chan.rank          = rank_ff;
   assign rsp_chan.wide_overflow = wovf_ff;
   assign rsp_chan.limit_hit     = lhit_ff;
   assign rsp_chan.entry_number  = enum_ff;
   assign rsp_chan.entry_steps   = esteps_ff;

endmodule
`default_nettype wire

/* src/clzrank_checker.sv */
`default_nettype none
`include "assert_macros.svh"
module clzrank_checker
   import clzrank_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [STEPS_W-1:0]  rsp_steps,
   input wire logic                rsp_admitted,
   input wire logic [RANK_W-1:0]   rsp_rank,
   input wire logic                rsp_wide_overflow,
   input wire logic                rsp_limit_hit,
   input wire logic [NUMBER_W-1:0] rsp_entry_number,
   input wire logic [STEPS_W-1:0]  rsp_entry_steps
);

   // A flagged count never enters the table.
   property p_flag_blocks_admit;
      rsp_valid |-> !(rsp_admitted && (rsp_wide_overflow || rsp_limit_hit));
   endproperty

   // A nonzero rank only comes with an admitted number.
   property p_rank_needs_admit;
      (rsp_valid && (rsp_rank != '0)) |-> rsp_admitted;
   endproperty

   // Hitting the limit leaves the count at the limit itself.
   property p_limit_count;
      (rsp_valid && rsp_limit_hit) |-> (rsp_steps == EFF_LIMIT);
   endproperty

   // A stalled result beat keeps its contents.
   property p_rsp_hold;
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_steps) && $stable(rsp_rank) &&
          $stable(rsp_entry_number) && $stable(rsp_entry_steps));
   endproperty

   `CLZ_ASSERT(a_flag_blocks_admit, p_flag_blocks_admit, "flagged number was admitted")
   `CLZ_ASSERT(a_rank_needs_admit, p_rank_needs_admit, "rank without admission")
   `CLZ_ASSERT(a_limit_count, p_limit_count, "limit flag with wrong count")
   `CLZ_ASSERT(a_rsp_hold, p_rsp_hold, "stalled result changed")

endmodule

bind collatz_length_top_ranker clzrank_checker u_clzrank_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_steps         (rsp_chan.steps),
   .rsp_admitted      (rsp_chan.admitted),
   .rsp_rank          (rsp_chan.rank),
   .rsp_wide_overflow (rsp_chan.wide_overflow),
   .rsp_limit_hit     (rsp_chan.limit_hit),
   .rsp_entry_number  (rsp_chan.entry_number),
   .rsp_entry_steps   (rsp_chan.entry_steps)
);
`default_nettype wire
